// File: hdl/stt_pkg.sv
// Shared types, codes and widths for the software timer table.
package stt_pkg;

  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 8;
  localparam int MAX_RES = 16;
  localparam int NRES_W  = $clog2(MAX_RES + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_FRAME  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  timer_slot;
    logic [31:0] period_ms;
    logic [32:0] begin_ms;
    logic        is_periodic;
    logic [47:0] raw_ticks;
  } stt_in_t;

  typedef struct packed {
    logic [3:0] fired_slot;
    logic [7:0] fire_count;
    logic       expired;
    logic       last_event;
  } stt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;
    logic cancel;
    logic load;
    logic conv;
    logic clr;
    logic step;
    logic push;
    logic next;
    logic flush;
  } stt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic due;
    logic cap_hit;
    logic cnt_zero;
    logic gone;
    logic idx_last;
    logic res_full;
  } stt_sts_t;

endpackage

// File: hdl/stt_ctrl.sv
// Controller state machine that sequences requests and the frame walk over the slots.
module stt_ctrl import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_req,
  input  stt_sts_t   sts,
  output logic       busy,
  output stt_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_ITER,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   fire;

  assign busy = busy_r;
  assign fire = sts.due && !sts.cap_hit && !sts.gone;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_req)
            REQ_ADD:    cmd.add    = 1'b1;
            REQ_CANCEL: cmd.cancel = 1'b1;
            REQ_FRAME: begin
              cmd.load  = 1'b1;
              state_nxt = ST_CONV;
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.res_full) begin
          state_nxt = ST_FLUSH;
        end else if (sts.active) begin
          cmd.clr   = 1'b1;
          state_nxt = ST_ITER;
        end else if (sts.idx_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.next = 1'b1;
        end
      end
      ST_ITER: begin
        if (fire) begin
          cmd.step = 1'b1;
        end else begin
          cmd.push = !sts.cnt_zero;
          if (sts.idx_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// File: hdl/stt_dp.sv
// Datapath with the slot table, time conversion, catch-up counter and result register.
module stt_dp import stt_pkg::*; #(
  parameter int TIMER_SLOTS = 16,
  parameter int CATCHUP_CAP = 255
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stt_in_t  in_beat,
  input  stt_cmd_t cmd,
  output stt_sts_t sts,
  output logic     out_valid,
  output stt_out_t out_beat
);

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic              active_r   [TIMER_SLOTS];
  logic              periodic_r [TIMER_SLOTS];
  logic [33:0]       start_r    [TIMER_SLOTS];
  logic [31:0]       period_r   [TIMER_SLOTS];

  logic [32:0]       now_r;
  logic [25:0]       sub_r;
  logic [SW-1:0]     idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              gone_r;
  logic [NRES_W-1:0] nres_r;

  logic              pend_v_r;
  logic [SW-1:0]     pend_idx_r;
  logic [CNT_W-1:0]  pend_cnt_r;
  logic              pend_gone_r;
  logic              out_valid_r;
  stt_out_t          out_r;

  logic              slot_ok;
  logic [SW-1:0]     wr_idx;
  logic [34:0]       due_sum;

  assign slot_ok = 32'(in_beat.timer_slot) < TIMER_SLOTS;
  assign wr_idx  = SW'(in_beat.timer_slot);
  assign due_sum = 35'(start_r[idx_r]) + 35'(period_r[idx_r]);

  assign sts.active   = active_r[idx_r];
  assign sts.due      = 35'(now_r) > due_sum;
  assign sts.cap_hit  = cnt_r == CNT_W'(CATCHUP_CAP);
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.gone     = gone_r;
  assign sts.idx_last = idx_r == SW'(TIMER_SLOTS - 1);
  assign sts.res_full = nres_r == NRES_W'(MAX_RES);

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // Slot table: active bits reset, the rest is valid only once written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        active_r[i] <= 1'b0;
      end
    end else if (cmd.add && slot_ok) begin
      active_r[wr_idx] <= 1'b1;
    end else if (cmd.cancel && slot_ok) begin
      active_r[wr_idx] <= 1'b0;
    end else if (cmd.step && !periodic_r[idx_r]) begin
      active_r[idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && slot_ok) begin
      periodic_r[wr_idx] <= in_beat.is_periodic;
      start_r[wr_idx]    <= 34'(in_beat.begin_ms);
      period_r[wr_idx]   <= in_beat.period_ms;
    end else if (cmd.step && periodic_r[idx_r]) begin
      start_r[idx_r] <= due_sum[33:0];
    end
  end

  // Walk registers and the tick to millisecond conversion.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= in_beat.raw_ticks[47:15] - 33'(in_beat.raw_ticks[47:21]);
      sub_r  <= in_beat.raw_ticks[47:22];
      idx_r  <= '0;
      nres_r <= '0;
    end else begin
      if (cmd.conv) begin
        now_r <= now_r - 33'(sub_r);
      end
      if (cmd.next) begin
        idx_r <= idx_r + SW'(1);
      end
      if (cmd.push) begin
        nres_r <= nres_r + NRES_W'(1);
      end
    end
    if (cmd.clr) begin
      cnt_r  <= '0;
      gone_r <= 1'b0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (!periodic_r[idx_r]) begin
        gone_r <= 1'b1;
      end
    end
  end

  // One result is held back so the final beat of a frame can be marked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.push || cmd.flush) && pend_v_r;
      if (cmd.push) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.flush) begin
      out_r.fired_slot <= SLOT_W'(pend_idx_r);
      out_r.fire_count <= pend_cnt_r;
      out_r.expired    <= pend_gone_r;
      out_r.last_event <= cmd.flush;
    end
    if (cmd.push) begin
      pend_idx_r  <= idx_r;
      pend_cnt_r  <= cnt_r;
      pend_gone_r <= gone_r;
    end
  end

endmodule

// File: hdl/software_timer_table.sv
// Top level of the software timer table: controller and datapath.
// Add and cancel requests take effect at the accepting edge and keep busy low.
// In a frame, the catch-up iteration shares one adder and runs one firing per cycle.
// Results leave one per strobe cycle and the receiver cannot stall them; the last
// beat of a frame follows its flush cycle.
// Synchronous reset marks every slot inactive and returns the controller to idle.
module software_timer_table import stt_pkg::*; #(
  parameter int TIMER_SLOTS = 16,
  parameter int CATCHUP_CAP = 255
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  stt_in_t  in_beat,
  output logic     out_valid,
  output stt_out_t out_beat
);

  stt_cmd_t cmd;
  stt_sts_t sts;

  // The controller decodes the request type and steps through the slots in
  // ascending order, issuing one command set per cycle.
  stt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_beat.req_type),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  // The datapath holds the slot table, compares the current time with each
  // slot's deadline and builds the result beats.
  stt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .CATCHUP_CAP (CATCHUP_CAP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule
